/* design/coverability_graph_successor_top_assert.svh */
// assertion macros used by the checker file
`ifndef COVERABILITY_GRAPH_SUCCESSOR_TOP_ASSERT_SVH
`define COVERABILITY_GRAPH_SUCCESSOR_TOP_ASSERT_SVH
// a condition must hold at every edge out of reset
`define CGS_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");
// an antecedent implies a consequent on the next edge
`define CGS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* design/cgs_pkg.sv */
// shared types and constants of the coverability graph engine
package cgs_pkg;
    localparam int PLACES = 8;
    localparam int TRANSITIONS = 8;
    localparam int NODES = 256;
    localparam int PW = $clog2(PLACES);
    localparam int TW = $clog2(TRANSITIONS);
    localparam int NW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam logic [13:0] OMEGA = 14'd10000;
    localparam logic [13:0] MAX_COUNT = 14'd9999;

    typedef enum logic [1:0] {
        ACT_LOAD_ARC = 2'd0,
        ACT_LOAD_TOK = 2'd1,
        ACT_START = 2'd2,
        ACT_EXPAND = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    localparam logic [0:0] REG_PLACES = 1'b0;
    localparam logic [0:0] REG_TRANS = 1'b1;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] transition_sel;
        logic [2:0] place_sel;
        logic [7:0] pre_amount;
        logic [7:0] post_amount;
        logic [13:0] initial_tokens;
        logic [7:0] node_select;
        logic [2:0] enabled_position;
    } in_item_t;

    typedef struct packed {
        logic [7:0] successor_index;
        logic is_new;
        logic [3:0] enabled_total;
        logic [8:0] nodes_stored;
        logic [1:0] status;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE, S_START_LD, S_STORE_CLR, S_EN_CHK, S_EN_WR,
        S_CHK_RD, S_CHK_WAIT, S_LIST_RD, S_FIRE_RD, S_FIRE,
        S_COV_RD, S_COV, S_EQ_RD, S_EQ, S_CNT_RD, S_DONE
    } state_t;
endpackage

/* design/cgs_ram.sv */
// generic single port write, single read port synchronous ram
module cgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic aclk,
    input  logic we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/coverability_graph_successor_top.sv */
// top level of the coverability graph engine
// Coverability graph engine, one request at a time. A load request (arc weights,
// initial tokens) puts its result in the output register at the accepting edge,
// so it is valid on the next cycle. Start stores node 0 and builds its enabled
// list. Expand checks the node and reads its enabled list, then fires the
// transition place by place. It then walks the stored nodes through the marking
// memory: all of them for the cover test, then for the equality test until a
// match is found. A new node is then stored with its enabled list; for a node
// that is found, its enabled count is read. The marking, enabled-list,
// enabled-count and arc-weight memories each have one write and one registered
// read port, and that read port sets the pace. Unloaded arcs read as zero
// through one loaded bit per arc. The result sits in an output register. A new
// request is accepted only once the previous result is taken, at the earliest in
// the same cycle.
module coverability_graph_successor_top (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [3:0] cfg_data,
    input  logic s_valid,
    output logic s_ready,
    input  cgs_pkg::in_item_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output cgs_pkg::out_item_t m_data
);
    localparam int PW = cgs_pkg::PW;
    localparam int TW = cgs_pkg::TW;
    localparam int NW = cgs_pkg::NW;
    localparam int CW = cgs_pkg::CW;

    // configuration registers
    logic [3:0] places_reg, trans_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            places_reg <= 4'd8;
            trans_reg <= 4'd8;
        end else if (cfg_we) begin
            if (cfg_index == cgs_pkg::REG_PLACES) places_reg <= cfg_data;
            else trans_reg <= cfg_data;
        end
    end
    // effective counts, clamped into 1..max
    logic [PW:0] np;
    logic [TW:0] nt;
    always_comb begin
        if (places_reg == 4'd0) np = (PW+1)'(1);
        else if (32'(places_reg) > cgs_pkg::PLACES) np = (PW+1)'(cgs_pkg::PLACES);
        else np = (PW+1)'(places_reg);
        if (trans_reg == 4'd0) nt = (TW+1)'(1);
        else if (32'(trans_reg) > cgs_pkg::TRANSITIONS) nt = (TW+1)'(cgs_pkg::TRANSITIONS);
        else nt = (TW+1)'(trans_reg);
    end

    // initial marking, reset to zero, in flip-flops
    logic [13:0] init_reg [cgs_pkg::PLACES];

    // arc weights {pre, post} per transition and place, with a loaded bit each
    logic wt_we;
    logic [TW+PW-1:0] wt_waddr, wt_raddr;
    logic [15:0] wt_wdata, wt_rdata;
    logic [cgs_pkg::TRANSITIONS*cgs_pkg::PLACES-1:0] wt_valid_reg;
    logic wt_rvalid_reg;

    // working marking of the successor
    logic [13:0] mk_reg [cgs_pkg::PLACES];

    // a covered node's row is gathered place by place, then applied at once
    logic [13:0] cov_row [cgs_pkg::PLACES];
    logic cov_raise;

    // memories
    logic mk_we, el_we, ec_we;
    logic [NW+PW-1:0] mk_waddr, mk_raddr;
    logic [13:0] mk_wdata, mk_rdata;
    logic [NW+TW-1:0] el_waddr, el_raddr;
    logic [TW-1:0] el_wdata, el_rdata;
    logic [NW-1:0] ec_waddr, ec_raddr;
    logic [TW:0] ec_wdata, ec_rdata;

    cgs_ram #(.WIDTH(14), .DEPTH(cgs_pkg::NODES * cgs_pkg::PLACES)) u_mk (
        .aclk(aclk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
        .raddr(mk_raddr), .rdata(mk_rdata));
    cgs_ram #(.WIDTH(TW), .DEPTH(cgs_pkg::NODES * cgs_pkg::TRANSITIONS)) u_el (
        .aclk(aclk), .we(el_we), .waddr(el_waddr), .wdata(el_wdata),
        .raddr(el_raddr), .rdata(el_rdata));
    cgs_ram #(.WIDTH(TW+1), .DEPTH(cgs_pkg::NODES)) u_ec (
        .aclk(aclk), .we(ec_we), .waddr(ec_waddr), .wdata(ec_wdata),
        .raddr(ec_raddr), .rdata(ec_rdata));
    cgs_ram #(.WIDTH(16), .DEPTH(cgs_pkg::TRANSITIONS * cgs_pkg::PLACES)) u_wt (
        .aclk(aclk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
        .raddr(wt_raddr), .rdata(wt_rdata));

    cgs_pkg::state_t state_reg, state_next;
    cgs_pkg::in_item_t req_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [NW-1:0] idx_reg, idx_next;     // node being stored or found
    logic [CW-1:0] q_reg, q_next;         // node walked in a scan
    logic [PW:0] p_reg, p_next;           // place counter
    logic [TW:0] t_reg, t_next;           // transition counter, or the one fired
    logic [TW:0] cnt_reg, cnt_next;       // enabled count under build
    logic flag_reg, flag_next;            // cover or equal so far
    logic out_valid_reg;
    cgs_pkg::out_item_t out_reg, out_next;
    logic out_load;

    // combinational helpers for place p_reg; weights were fetched in the previous cycle
    logic [PW-1:0] pi;
    logic [TW-1:0] ti;
    logic [7:0] wa, wb;
    logic [14:0] fired;
    always_comb begin
        pi = p_reg[PW-1:0];
        ti = t_reg[TW-1:0];
        wa = wt_rvalid_reg ? wt_rdata[15:8] : 8'd0;
        wb = wt_rvalid_reg ? wt_rdata[7:0] : 8'd0;
        fired = 15'(mk_rdata) + 15'(wb);
        if (fired < 15'(wa)) fired = 15'd0;
        else fired = fired - 15'(wa);
    end

    assign s_ready = (state_reg == cgs_pkg::S_IDLE) && !(out_valid_reg && !m_ready);
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    // arc weight loads go straight into the weight memory
    assign wt_we = s_valid && s_ready && (s_data.action == cgs_pkg::ACT_LOAD_ARC);
    assign wt_waddr = {s_data.transition_sel[TW-1:0], s_data.place_sel[PW-1:0]};
    assign wt_wdata = {s_data.pre_amount, s_data.post_amount};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cgs_pkg::S_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wt_valid_reg <= '0;
            for (int p = 0; p < cgs_pkg::PLACES; p++) init_reg[p] <= '0;
        end else if (s_valid && s_ready) begin
            if (wt_we) begin
                wt_valid_reg[wt_waddr] <= 1'b1;
            end else if (s_data.action == cgs_pkg::ACT_LOAD_TOK
                         && s_data.initial_tokens <= cgs_pkg::MAX_COUNT) begin
                init_reg[s_data.place_sel[PW-1:0]] <= s_data.initial_tokens;
            end
        end
    end

    // working marking updates
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            cgs_pkg::S_START_LD: begin
                for (int p = 0; p < cgs_pkg::PLACES; p++)
                    mk_reg[p] <= (p < 32'(np)) ? init_reg[p] : 14'd0;
            end
            cgs_pkg::S_FIRE: begin
                if (!(wa == wb && wa != 8'd0) && mk_rdata != cgs_pkg::OMEGA)
                    mk_reg[pi] <= fired[13:0];
                else mk_reg[pi] <= mk_rdata;
            end
            cgs_pkg::S_COV: begin
                // covered node: raise places that grew, last place straight from memory
                if (cov_raise) begin
                    for (int p = 0; p < cgs_pkg::PLACES; p++)
                        if (p < 32'(np)
                            && mk_reg[p] > ((p == 32'(pi)) ? mk_rdata : cov_row[p]))
                            mk_reg[p] <= cgs_pkg::OMEGA;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == cgs_pkg::S_COV && !p_reg[PW] && 32'(p_reg) < cgs_pkg::PLACES)
            cov_row[pi] <= mk_rdata;
    end

    always_ff @(posedge aclk) begin
        req_reg <= (s_valid && s_ready) ? s_data : req_reg;
        idx_reg <= idx_next;
        q_reg <= q_next;
        p_reg <= p_next;
        t_reg <= t_next;
        cnt_reg <= cnt_next;
        flag_reg <= flag_next;
        wt_rvalid_reg <= wt_valid_reg[wt_raddr];
        if (out_load) out_reg <= out_next;
    end

    logic last_p;
    always_comb begin
        last_p = (p_reg + 1'b1) >= np;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        q_next = q_reg;
        p_next = p_reg;
        t_next = t_reg;
        cnt_next = cnt_reg;
        flag_next = flag_reg;
        out_load = 1'b0;
        out_next = '0;
        cov_raise = 1'b0;
        mk_we = 1'b0;
        mk_waddr = {idx_reg, pi};
        mk_wdata = (32'(p_reg) < 32'(np)) ? mk_reg[pi] : 14'd0;
        mk_raddr = {q_reg[NW-1:0], pi};
        el_we = 1'b0;
        el_waddr = {idx_reg, cnt_reg[TW-1:0]};
        el_wdata = ti;
        el_raddr = {req_reg.node_select[NW-1:0], req_reg.enabled_position[TW-1:0]};
        ec_we = 1'b0;
        ec_waddr = idx_reg;
        ec_wdata = cnt_reg;
        ec_raddr = req_reg.node_select[NW-1:0];
        unique case (state_reg)
            cgs_pkg::S_IDLE: begin
                if (s_valid && s_ready) begin
                    unique case (s_data.action)
                        cgs_pkg::ACT_LOAD_ARC, cgs_pkg::ACT_LOAD_TOK: begin
                            out_load = 1'b1;
                            out_next.nodes_stored = 9'(count_reg);
                            out_next.status = (s_data.action == cgs_pkg::ACT_LOAD_TOK
                                && s_data.initial_tokens > cgs_pkg::MAX_COUNT)
                                ? cgs_pkg::ST_OVERFLOW : cgs_pkg::ST_OK;
                        end
                        cgs_pkg::ACT_START: begin
                            count_next = '0;
                            idx_next = '0;
                            state_next = cgs_pkg::S_START_LD;
                        end
                        default: begin
                            state_next = cgs_pkg::S_CHK_RD;
                        end
                    endcase
                end
            end
            cgs_pkg::S_START_LD: begin
                p_next = '0;
                state_next = cgs_pkg::S_STORE_CLR;
            end
            // write the marking and reset list slots, then build the list
            cgs_pkg::S_STORE_CLR: begin
                mk_we = 1'b1;
                el_we = 1'b1;
                el_waddr = {idx_reg, pi[TW-1:0]};
                el_wdata = '0;
                p_next = p_reg + 1'b1;
                if (32'(p_reg) == cgs_pkg::PLACES - 1) begin
                    t_next = '0;
                    cnt_next = '0;
                    p_next = '0;
                    flag_next = 1'b1;
                    state_next = cgs_pkg::S_EN_CHK;
                end
            end
            cgs_pkg::S_EN_CHK: begin
                if (mk_reg[pi] < 14'(wa)) flag_next = 1'b0;
                p_next = p_reg + 1'b1;
                if (last_p) state_next = cgs_pkg::S_EN_WR;
            end
            cgs_pkg::S_EN_WR: begin
                if (flag_reg) begin
                    el_we = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                p_next = '0;
                flag_next = 1'b1;
                t_next = t_reg + 1'b1;
                if (t_reg + 1'b1 >= nt) begin
                    ec_we = 1'b1;
                    ec_wdata = flag_reg ? cnt_reg + 1'b1 : cnt_reg;
                    if (req_reg.action == cgs_pkg::ACT_START) count_next = (CW)'(1);
                    else count_next = count_reg + 1'b1;
                    out_load = 1'b1;
                    out_next.successor_index = 8'(idx_reg);
                    out_next.is_new = 1'b1;
                    out_next.enabled_total = 4'(ec_wdata);
                    out_next.nodes_stored = 9'(count_next);
                    out_next.status = cgs_pkg::ST_OK;
                    state_next = cgs_pkg::S_IDLE;
                end else begin
                    state_next = cgs_pkg::S_EN_CHK;
                end
            end
            cgs_pkg::S_CHK_RD: begin
                state_next = cgs_pkg::S_CHK_WAIT;
            end
            cgs_pkg::S_CHK_WAIT: begin
                if (9'(req_reg.node_select) >= 9'(count_reg)
                    || 4'(req_reg.enabled_position) >= 4'(ec_rdata)) begin
                    out_load = 1'b1;
                    out_next.nodes_stored = 9'(count_reg);
                    out_next.status = cgs_pkg::ST_BAD;
                    state_next = cgs_pkg::S_IDLE;
                end else begin
                    state_next = cgs_pkg::S_LIST_RD;
                end
            end
            cgs_pkg::S_LIST_RD: begin
                t_next = {1'b0, el_rdata};
                q_next = CW'(req_reg.node_select);
                p_next = '0;
                state_next = cgs_pkg::S_FIRE_RD;
            end
            cgs_pkg::S_FIRE_RD: begin
                state_next = cgs_pkg::S_FIRE;
            end
            cgs_pkg::S_FIRE: begin
                if (!(wa == wb && wa != 8'd0) && mk_rdata != cgs_pkg::OMEGA
                    && fired > 15'(cgs_pkg::MAX_COUNT)) begin
                    out_load = 1'b1;
                    out_next.nodes_stored = 9'(count_reg);
                    out_next.status = cgs_pkg::ST_OVERFLOW;
                    state_next = cgs_pkg::S_IDLE;
                end else if (last_p) begin
                    q_next = '0;
                    p_next = '0;
                    flag_next = 1'b1;
                    state_next = cgs_pkg::S_COV_RD;
                end else begin
                    p_next = p_reg + 1'b1;
                    state_next = cgs_pkg::S_FIRE_RD;
                end
            end
            // cover pass: node q is covered if mk >= row everywhere
            cgs_pkg::S_COV_RD: begin
                state_next = cgs_pkg::S_COV;
            end
            cgs_pkg::S_COV: begin
                if (mk_reg[pi] < mk_rdata) flag_next = 1'b0;
                if (last_p) begin
                    cov_raise = flag_reg && !(mk_reg[pi] < mk_rdata);
                    flag_next = 1'b1;
                    p_next = '0;
                    q_next = q_reg + 1'b1;
                    if (q_reg + 1'b1 >= count_reg) begin
                        q_next = '0;
                        state_next = cgs_pkg::S_EQ_RD;
                    end else begin
                        state_next = cgs_pkg::S_COV_RD;
                    end
                end else begin
                    p_next = p_reg + 1'b1;
                    state_next = cgs_pkg::S_COV_RD;
                end
            end
            cgs_pkg::S_EQ_RD: begin
                state_next = cgs_pkg::S_EQ;
            end
            cgs_pkg::S_EQ: begin
                if (mk_reg[pi] != mk_rdata) flag_next = 1'b0;
                if (last_p) begin
                    if (flag_reg && mk_reg[pi] == mk_rdata) begin
                        idx_next = q_reg[NW-1:0];
                        state_next = cgs_pkg::S_CNT_RD;
                    end else if (q_reg + 1'b1 >= count_reg) begin
                        if (32'(count_reg) >= cgs_pkg::NODES) begin
                            out_load = 1'b1;
                            out_next.nodes_stored = 9'(count_reg);
                            out_next.status = cgs_pkg::ST_FULL;
                            state_next = cgs_pkg::S_IDLE;
                        end else begin
                            idx_next = count_reg[NW-1:0];
                            p_next = '0;
                            state_next = cgs_pkg::S_STORE_CLR;
                        end
                    end else begin
                        flag_next = 1'b1;
                        p_next = '0;
                        q_next = q_reg + 1'b1;
                        state_next = cgs_pkg::S_EQ_RD;
                    end
                end else begin
                    p_next = p_reg + 1'b1;
                    state_next = cgs_pkg::S_EQ_RD;
                end
            end
            cgs_pkg::S_CNT_RD: begin
                ec_raddr = idx_reg;
                state_next = cgs_pkg::S_DONE;
            end
            cgs_pkg::S_DONE: begin
                out_load = 1'b1;
                out_next.successor_index = 8'(idx_reg);
                out_next.is_new = 1'b0;
                out_next.enabled_total = 4'(ec_rdata);
                out_next.nodes_stored = 9'(count_reg);
                out_next.status = cgs_pkg::ST_OK;
                state_next = cgs_pkg::S_IDLE;
            end
            default: begin
                state_next = cgs_pkg::S_IDLE;
            end
        endcase
        // weights for the next cycle's transition and place
        wt_raddr = {t_next[TW-1:0], p_next[PW-1:0]};
    end
endmodule

/* design/cgs_checker.sv */
// port level checker of the coverability graph engine and its bind
`include "coverability_graph_successor_top_assert.svh"
module cgs_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input cgs_pkg::out_item_t m_data
);
    `CGS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `CGS_ASSERT_ALWAYS(a_nodes_range, aclk, aresetn, !m_valid || m_data.nodes_stored <= 9'd256)
    `CGS_ASSERT_ALWAYS(a_new_ok, aclk, aresetn, !m_valid || !m_data.is_new || m_data.status == cgs_pkg::ST_OK)
    `CGS_ASSERT_NEXT(a_busy_after_req, aclk, aresetn, s_valid && s_ready, !s_ready || m_valid)
endmodule

bind coverability_graph_successor_top cgs_checker u_cgs_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));
